// ----- hw/rtl/srkv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srkv_pkg
// Shared types and constants of the sorted-run key-value map.
// ----------------------------------------------------------------------------
package srkv_pkg;

    localparam int CAP_W      = 7;
    localparam int FOUND_W    = 32;
    localparam int COUNT_W    = 7;
    localparam int OUT_DATA_W = 40;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_INSERT  = 2'd1,
        OP_REPLACE = 2'd2,
        OP_FIND    = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PROBE,
        ST_CMP,
        ST_EQ,
        ST_INS,
        ST_MTEST,
        ST_MRD,
        ST_MSEL,
        ST_CRD,
        ST_CWR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [FOUND_W-1:0] found;
        logic               status;
    } t_res;

endpackage

// ----- hw/rtl/sorted_run_key_value_map_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_run_key_value_map_core
// Bounded key-value multimap kept as sorted runs, with stream ports.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         op, key, value
// m_axis    out        status, found_value, entry_count
// cfg       in         capacity
//
// A request runs from a clear, the shortest, to an insert with a
// full merge cascade, the longest; each merge step and each binary-search
// probe waits on the registered memory reads. Reset is synchronous and
// active low and empties the map; capacity returns to 64. s_axis_tready is
// high only while the sequencer is idle; one result waits in the output
// register while the next request runs.
module sorted_run_key_value_map_core #(
    parameter int DEPTH       = 64,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // op, key, value, zero pad
    input  logic [((2 + KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // status, found_value, entry_count
    output logic [srkv_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [srkv_pkg::CAP_W-1:0] i_cfg_data
);
    import srkv_pkg::*;

    logic [CAP_W-1:0] r_cap;
    logic             r_ovalid;
    t_res             r_ores;
    logic             w_idle, w_done, w_load, w_start;
    t_res             w_res;

    assign w_start       = s_axis_tvalid && w_idle;
    assign s_axis_tready = w_idle;
    assign o_cfg_ready   = 1'b1;
    assign w_load        = w_done && (!r_ovalid || m_axis_tready);

    srkv_seq #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_op    (t_op'(s_axis_tdata[1:0])),
        .i_key   (s_axis_tdata[2 +: KEY_WIDTH]),
        .i_val   (s_axis_tdata[2 + KEY_WIDTH +: VALUE_WIDTH]),
        .i_cap   (r_cap),
        .i_take  (w_load),
        .o_idle  (w_idle),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (w_load) begin
            r_ores <= w_res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_ores;

endmodule

// ----- hw/rtl/srkv_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srkv_seq
// Sequencer with the entry memory, the merge buffer and the key compare
// logic; runs the binary searches, the insert and the merge cascade.
// ----------------------------------------------------------------------------
module srkv_seq #(
    parameter int DEPTH       = 64,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  srkv_pkg::t_op            i_op,
    input  logic [KEY_WIDTH-1:0]     i_key,
    input  logic [VALUE_WIDTH-1:0]   i_val,
    input  logic [srkv_pkg::CAP_W-1:0] i_cap,
    input  logic                     i_take,
    output logic                     o_idle,
    output logic                     o_done,
    output srkv_pkg::t_res           o_res
);
    import srkv_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam int WW = KEY_WIDTH + VALUE_WIDTH;

    logic [WW-1:0] r_mem [DEPTH];
    logic [WW-1:0] r_tmp [DEPTH];
    logic [WW-1:0] r_rda, r_rdb, r_trd;

    logic          w_we, w_twe;
    logic [AW-1:0] w_wa, w_ra, w_rb, w_twa, w_tra;
    logic [WW-1:0] w_wd, w_twd;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [CW-1:0] r_cnt, n_cnt, r_rest, n_rest, r_bit, n_bit;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid, r_base, n_base;
    logic [CW-1:0] r_x, n_x, r_i, n_i, r_j, n_j, r_k, n_k;
    logic [AW-1:0] r_addr, n_addr;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic               r_status, n_status;
    logic [FOUND_W-1:0] r_found, n_found;

    logic [KEY_WIDTH-1:0] w_ka, w_kb;
    logic [CW-1:0]        w_m, w_rest;
    logic [LW-1:0]        w_cap, w_dep, w_cntw, w_lim;
    logic                 w_full, w_take;

    assign w_ka   = r_rda[WW-1:VALUE_WIDTH];
    assign w_kb   = r_rdb[WW-1:VALUE_WIDTH];
    assign w_m    = r_lo + ((r_hi - r_lo) >> 1);
    assign w_rest = r_rest & ~r_bit;
    assign w_cap  = LW'(i_cap);
    assign w_dep  = LW'(DEPTH);
    assign w_cntw = LW'(r_cnt);
    assign w_lim  = (w_cap < w_dep) ? w_cap : w_dep;
    assign w_full = (w_cntw >= w_lim);
    assign w_take = (r_j < r_hi) && ((r_i >= r_mid) || (w_kb < w_ka));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_twe) begin
            r_tmp[w_twa] <= w_twd;
        end
        r_rda <= r_mem[w_ra];
        r_rdb <= r_mem[w_rb];
        r_trd <= r_tmp[w_tra];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_op)
                        OP_CLEAR:  n_state = ST_DONE;
                        OP_INSERT: n_state = ST_INS;
                        default:   n_state = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_rest == '0) begin
                    n_state = (r_op == OP_REPLACE) ? ST_INS : ST_DONE;
                end else if ((r_rest & r_bit) != '0) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (r_lo < r_hi) begin
                    n_state = ST_CMP;
                end else if (r_lo != '0) begin
                    n_state = ST_EQ;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_CMP:   n_state = ST_PROBE;
            ST_EQ:    n_state = (w_ka == r_key) ? ST_DONE : ST_SCAN;
            ST_INS:   n_state = w_full ? ST_DONE : ST_MTEST;
            ST_MTEST: n_state = ((r_x & r_bit) != '0) ? ST_MRD : ST_DONE;
            ST_MRD:   n_state = ((r_i < r_mid) || (r_j < r_hi)) ? ST_MSEL : ST_CRD;
            ST_MSEL:  n_state = ST_MRD;
            ST_CRD:   n_state = (r_k < (r_hi - r_base)) ? ST_CWR : ST_MTEST;
            ST_CWR:   n_state = ST_CRD;
            ST_DONE:  n_state = i_take ? ST_IDLE : ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_op = r_op;     n_cnt = r_cnt;   n_rest = r_rest; n_bit = r_bit;
        n_lo = r_lo;     n_hi = r_hi;     n_mid = r_mid;   n_base = r_base;
        n_x = r_x;       n_i = r_i;       n_j = r_j;       n_k = r_k;
        n_addr = r_addr; n_key = r_key;   n_val = r_val;
        n_status = r_status; n_found = r_found;
        w_we = 1'b0;  w_wa = '0; w_wd = '0;
        w_twe = 1'b0; w_twa = '0; w_twd = '0;
        w_ra = '0; w_rb = '0; w_tra = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_op = i_op; n_key = i_key; n_val = i_val;
                    n_status = 1'b0; n_found = '0;
                    n_rest = r_cnt; n_bit = CW'(1);
                    if (i_op == OP_CLEAR) begin
                        n_cnt = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rest == '0) begin
                    n_status = (r_op == OP_FIND);
                end else if ((r_rest & r_bit) != '0) begin
                    n_rest = w_rest; n_base = w_rest; n_lo = '0; n_hi = r_bit;
                end else begin
                    n_bit = r_bit << 1;
                end
            end
            ST_PROBE: begin
                if (r_lo < r_hi) begin
                    n_mid = w_m;
                    w_ra = AW'(r_base + w_m);
                end else if (r_lo != '0) begin
                    w_ra = AW'(r_base + r_lo - CW'(1));
                    n_addr = w_ra;
                end else begin
                    n_bit = r_bit << 1;
                end
            end
            ST_CMP: begin
                if (r_key < w_ka) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + CW'(1);
                end
            end
            ST_EQ: begin
                if (w_ka == r_key) begin
                    if (r_op == OP_FIND) begin
                        n_found = FOUND_W'(r_rda[VALUE_WIDTH-1:0]);
                    end else begin
                        w_we = 1'b1; w_wa = r_addr; w_wd = {r_key, r_val};
                    end
                end else begin
                    n_bit = r_bit << 1;
                end
            end
            ST_INS: begin
                if (w_full) begin
                    n_status = 1'b1;
                end else begin
                    w_we = 1'b1; w_wa = AW'(r_cnt); w_wd = {r_key, r_val};
                    n_cnt = r_cnt + CW'(1);
                    n_x = r_cnt; n_bit = CW'(1);
                end
            end
            ST_MTEST: begin
                if ((r_x & r_bit) != '0) begin
                    n_base = r_x & ~r_bit;
                    n_x    = r_x & ~r_bit;
                    n_mid  = (r_x & ~r_bit) + r_bit;
                    n_hi   = (r_x & ~r_bit) + (r_bit << 1);
                    n_i    = r_x & ~r_bit;
                    n_j    = (r_x & ~r_bit) + r_bit;
                    n_k    = '0;
                end
            end
            ST_MRD: begin
                w_ra = AW'(r_i);
                w_rb = AW'(r_j);
                if (!((r_i < r_mid) || (r_j < r_hi))) begin
                    n_k = '0;
                end
            end
            ST_MSEL: begin
                w_twe = 1'b1; w_twa = AW'(r_k);
                w_twd = w_take ? r_rdb : r_rda;
                if (w_take) begin
                    n_j = r_j + CW'(1);
                end else begin
                    n_i = r_i + CW'(1);
                end
                n_k = r_k + CW'(1);
            end
            ST_CRD: begin
                w_tra = AW'(r_k);
                if (!(r_k < (r_hi - r_base))) begin
                    n_bit = r_bit << 1;
                end
            end
            ST_CWR: begin
                w_we = 1'b1; w_wa = AW'(r_base + r_k); w_wd = r_trd;
                n_k = r_k + CW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_op <= n_op;     r_rest <= n_rest; r_bit <= n_bit;
        r_lo <= n_lo;     r_hi <= n_hi;     r_mid <= n_mid; r_base <= n_base;
        r_x <= n_x;       r_i <= n_i;       r_j <= n_j;     r_k <= n_k;
        r_addr <= n_addr; r_key <= n_key;   r_val <= n_val;
        r_status <= n_status; r_found <= n_found;
    end

    assign o_idle       = (r_state == ST_IDLE);
    assign o_done       = (r_state == ST_DONE);
    assign o_res.status = r_status;
    assign o_res.found  = r_found;
    assign o_res.count  = COUNT_W'(r_cnt);

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count exceeds depth");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_idle && i_start) |=> !o_idle)
        else $error("request accepted but sequencer stayed idle");
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MSEL || r_state == ST_CWR || r_state == ST_CMP) |=> $stable(r_cnt))
        else $error("entry count changed during search or merge");
    a_merge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MSEL) |-> (r_k < (r_hi - r_base)))
        else $error("merge output overruns run pair");
`endif

endmodule
